>>> rtl/ring_buffer_packet_extractor_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ring buffer packet extractor
// Shared property forms, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_PACKET_EXTRACTOR_TOP_ASSERT_SVH
`define RING_BUFFER_PACKET_EXTRACTOR_TOP_ASSERT_SVH

// condition holds at every edge
`define RBPE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define RBPE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rbpe_pkg.sv
// ----------------------------------------------------------------------------
// rbpe_pkg
// Types and constants shared by the ring buffer packet extractor.
// ----------------------------------------------------------------------------
package rbpe_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int BYTE_W      = 8;
    localparam int FILL_W      = 6;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int MIN_WAIT    = 4;
    localparam int MIN_PKT_LEN = 3;
    localparam int CMD_Q_DEPTH = 2;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hAA;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_GET   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_STORED   = 2'd0,
        KIND_DROPPED  = 2'd1,
        KIND_PKT_BYTE = 2'd2,
        KIND_NO_PKT   = 2'd3
    } t_kind;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [FILL_W-1:0] fill;
    } t_result;

endpackage

>>> rtl/rbpe_ram.sv
// ----------------------------------------------------------------------------
// rbpe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rbpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rbpe_front.sv
// ----------------------------------------------------------------------------
// rbpe_front
// Input stage: takes stream transfers and decodes them into commands.
// ----------------------------------------------------------------------------
module rbpe_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [rbpe_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] data_byte
    input  logic                           s_axis_tuser,  // [0] req_type
    output logic                           o_cmd_valid,
    input  logic                           i_cmd_ready,
    output rbpe_pkg::t_cmd                 o_cmd
);
    import rbpe_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    assign s_axis_tready = !r_valid || i_cmd_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (r_valid && i_cmd_ready) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid = 1'b1;
            n_cmd.op = t_op'(s_axis_tuser);
            unique case (t_op'(s_axis_tuser))
                OP_WRITE: n_cmd.data = s_axis_tdata[BYTE_W-1:0];
                OP_GET:   n_cmd.data = '0;
                default:  n_cmd.data = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

>>> rtl/rbpe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rbpe_cmd_fifo
// Short command queue between the input stage and the ring engine.
// ----------------------------------------------------------------------------
`include "ring_buffer_packet_extractor_top_assert.svh"

module rbpe_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  rbpe_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output rbpe_pkg::t_cmd o_pop_cmd
);
    import rbpe_pkg::*;

    localparam int QAW = $clog2(CMD_Q_DEPTH);
    localparam int QCW = $clog2(CMD_Q_DEPTH + 1);
    localparam logic [QCW-1:0] Q_FULL = QCW'(CMD_Q_DEPTH);

    t_cmd           r_mem [CMD_Q_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_count != Q_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    `RBPE_ASSERT_ALWAYS(a_q_count_max, r_count <= Q_FULL, "command queue overfilled")
    `RBPE_ASSERT_IMPL(a_q_pop_nonempty, pop, r_count != '0, "pop from empty queue")
    `RBPE_ASSERT_NEXT(a_q_count_up, push && !pop, r_count == $past(r_count) + 1'b1,
        "queue count missed a push")

endmodule

>>> rtl/rbpe_back.sv
// ----------------------------------------------------------------------------
// rbpe_back
// Ring engine: stores bytes, hunts and checks packets, drives the result
// register.
// ----------------------------------------------------------------------------
`include "ring_buffer_packet_extractor_top_assert.svh"

module rbpe_back #(
    parameter int DEPTH = rbpe_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  rbpe_pkg::t_cmd    i_cmd,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output rbpe_pkg::t_result o_res
);
    import rbpe_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW:0]     DEPTH_W   = (PW+1)'(DEPTH);
    localparam logic [PW-1:0]   LAST_IDX  = PW'(DEPTH - 1);
    localparam logic [PW-1:0]   MIN_LEN_P = PW'(MIN_PKT_LEN);
    localparam logic [BYTE_W-1:0] MAX_LEN_B = BYTE_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HUNT,
        S_HDR,
        S_LEN,
        S_SUM,
        S_NOPKT,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [PW-1:0]     r_rp, n_rp;
    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_idx, n_idx;
    logic [PW-1:0]     r_len, n_len;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic [PW-1:0]     fill;
    logic [PW:0]       fill_diff;
    logic              out_free;
    logic              ram_we;
    logic [PW-1:0]     rd_off;
    logic [PW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              len_bad;
    logic              pkt_last;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[PW-1:0];
    endfunction

    always_comb begin
        fill_diff = {1'b0, r_wp} - {1'b0, r_rp};
        if (r_wp < r_rp) begin
            fill_diff = fill_diff + DEPTH_W;
        end
        fill = fill_diff[PW-1:0];
    end

    assign out_free = !r_out_valid || i_res_ready;
    assign len_bad  = (rd_data < BYTE_W'(MIN_PKT_LEN)) || (rd_data > MAX_LEN_B);
    assign pkt_last = (r_idx == r_len - 1'b1);
    assign rd_addr  = wrap_add(r_rp, rd_off);

    rbpe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_cmd.data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_idx       = r_idx;
        n_len       = r_len;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        rd_off      = '0;
        o_cmd_ready = 1'b0;

        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_ready = 1'b1;
                    if (i_cmd.op == OP_WRITE) begin
                        n_out_valid = 1'b1;
                        n_out.data  = '0;
                        n_out.last  = 1'b1;
                        if (fill == LAST_IDX) begin
                            n_out.kind = KIND_DROPPED;
                            n_out.fill = FILL_W'(fill);
                        end else begin
                            ram_we     = 1'b1;
                            n_wp       = wrap_add(r_wp, PW'(1));
                            n_out.kind = KIND_STORED;
                            n_out.fill = FILL_W'(fill) + FILL_W'(1);
                        end
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_HUNT: begin
                rd_off = '0;
                if (fill < PW'(MIN_WAIT)) begin
                    n_state = S_NOPKT;
                end else begin
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                rd_off = PW'(1);
                if (rd_data != HDR_BYTE) begin
                    n_rp    = wrap_add(r_rp, PW'(1));
                    n_state = S_HUNT;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                rd_off = PW'(2);
                if (len_bad) begin
                    n_rp    = wrap_add(r_rp, PW'(1));
                    n_state = S_HUNT;
                end else if (BYTE_W'(fill) < rd_data) begin
                    n_state = S_NOPKT;
                end else begin
                    n_len   = rd_data[PW-1:0];
                    n_sum   = HDR_BYTE + rd_data;
                    n_idx   = PW'(2);
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (pkt_last) begin
                    rd_off = '0;
                    if (r_sum != rd_data) begin
                        n_rp    = wrap_add(r_rp, PW'(1));
                        n_state = S_HUNT;
                    end else begin
                        n_idx   = '0;
                        n_state = S_EMIT;
                    end
                end else begin
                    rd_off = r_idx + 1'b1;
                    n_sum  = r_sum + rd_data;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_NOPKT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.kind  = KIND_NO_PKT;
                    n_out.data  = '0;
                    n_out.last  = 1'b1;
                    n_out.fill  = FILL_W'(fill);
                    n_state     = S_IDLE;
                end
            end
            S_EMIT: begin
                rd_off = out_free ? PW'(1) : '0;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.kind  = KIND_PKT_BYTE;
                    n_out.data  = rd_data;
                    n_out.last  = pkt_last;
                    n_out.fill  = FILL_W'(fill) - FILL_W'(1);
                    n_rp        = wrap_add(r_rp, PW'(1));
                    n_idx       = r_idx + 1'b1;
                    if (pkt_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
        end
        r_idx <= n_idx;
        r_len <= n_len;
        r_sum <= n_sum;
        r_out <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    `RBPE_ASSERT_ALWAYS(a_rb_ptr_range, (r_rp <= LAST_IDX) && (r_wp <= LAST_IDX),
        "ring pointer out of range")
    `RBPE_ASSERT_IMPL(a_rb_no_full_write, ram_we, fill != LAST_IDX,
        "byte written into a full ring")
    `RBPE_ASSERT_IMPL(a_rb_emit_idx, r_state == S_EMIT, r_idx < r_len,
        "packet byte index past length")
    `RBPE_ASSERT_IMPL(a_rb_sum_len, r_state == S_SUM,
        (r_len >= MIN_LEN_P) && (r_idx < r_len), "checksum scan on bad length")
    `RBPE_ASSERT_NEXT(a_rb_last_idle, (r_state == S_EMIT) && out_free && pkt_last,
        r_state == S_IDLE, "engine kept running after last packet byte")

endmodule

>>> rtl/ring_buffer_packet_extractor_top.sv
// ----------------------------------------------------------------------------
// ring_buffer_packet_extractor_top
// Byte ring buffer with a header, length and checksum packet extractor.
// ----------------------------------------------------------------------------
// Input stream: tuser selects a write of tdata[7:0] (0) or a packet get (1).
// Output stream: tuser is the result kind (stored, dropped, packet byte,
// no packet), tdata carries the packet byte and the ring fill level after the
// result, tlast marks the final result of each input transfer.
// A write's result passes the input stage, the command queue and the result
// register; writes sustain one per cycle while no get runs and the output
// is taken. A get walks the ring through the single read port of the ring
// memory: it discards non-header bytes one by one, restarts one byte on after
// a bad length or a failed checksum, reads a candidate packet to check its
// checksum, then emits the packet bytes, one per result.
// The input stage and a two-entry command queue keep taking transfers
// while the engine is busy or the output stalls; a stalled output holds
// its result and the engine waits.
// Reset empties the ring (both pointers to zero) and drops queued commands;
// the ring memory itself is not cleared.
// ----------------------------------------------------------------------------
module ring_buffer_packet_extractor_top #(
    parameter int DEPTH = rbpe_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [rbpe_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] data_byte
    input  logic                           s_axis_tuser,  // [0] req_type
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rbpe_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [7:0] out_byte, [13:8] fill_level
    output logic [1:0]                     m_axis_tuser,  // [1:0] result_kind
    output logic                           m_axis_tlast
);
    import rbpe_pkg::*;

    logic    fe_valid;
    logic    fe_ready;
    t_cmd    fe_cmd;
    logic    q_valid;
    logic    q_ready;
    t_cmd    q_cmd;
    t_result res;

    rbpe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (fe_valid),
        .i_cmd_ready   (fe_ready),
        .o_cmd         (fe_cmd)
    );

    rbpe_cmd_fifo u_cmd_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fe_valid),
        .o_push_ready (fe_ready),
        .i_push_cmd   (fe_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    rbpe_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = M_TDATA_W'({res.fill, res.data});
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
